### rtl/sexpr_token_lexer_macros.svh
// ----------------------------------------------------------------------------
// sexpr_token_lexer_macros.svh
// Assertion macros used by the lexer's checker file.
// ----------------------------------------------------------------------------
`ifndef SEXPR_TOKEN_LEXER_MACROS_SVH
`define SEXPR_TOKEN_LEXER_MACROS_SVH

// Check cons in the same cycle whenever ante holds.
`define STL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sexpr_token_lexer: check failed");

// Check cons in the cycle after ante holds.
`define STL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sexpr_token_lexer: check failed");

`endif

### rtl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and codes of the s-expression token lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

    localparam int LINE_FIELD_W = 24;
    localparam int COL_FIELD_W  = 16;
    localparam int VALUE_W      = 63;

    localparam logic [3:0] KIND_END     = 4'd0;
    localparam logic [3:0] KIND_LPAREN  = 4'd1;
    localparam logic [3:0] KIND_RPAREN  = 4'd2;
    localparam logic [3:0] KIND_LBRACE  = 4'd3;
    localparam logic [3:0] KIND_RBRACE  = 4'd4;
    localparam logic [3:0] KIND_LBRACK  = 4'd5;
    localparam logic [3:0] KIND_RBRACK  = 4'd6;
    localparam logic [3:0] KIND_INT     = 4'd7;
    localparam logic [3:0] KIND_IDENT   = 4'd8;
    localparam logic [3:0] KIND_STRING  = 4'd9;
    localparam logic [3:0] KIND_BADCHAR = 4'd10;
    localparam logic [3:0] KIND_UNTERM  = 4'd11;

    typedef enum logic [3:0] {
        CLS_SPACE,
        CLS_QUOTE,
        CLS_LPAREN,
        CLS_RPAREN,
        CLS_LBRACE,
        CLS_RBRACE,
        CLS_LBRACK,
        CLS_RBRACK,
        CLS_ZERO,
        CLS_DIGIT,
        CLS_IDENT,
        CLS_OTHER
    } char_class_t;

    // One classified source byte on its way from front to back.
    typedef struct packed {
        logic [7:0]  ch;
        logic        eoi;
        logic        newline;
        char_class_t cls;
    } item_t;

    typedef struct packed {
        logic [3:0]              kind;
        logic [LINE_FIELD_W-1:0] line;
        logic [COL_FIELD_W-1:0]  column;
        logic [VALUE_W-1:0]      value;
        logic [7:0]              text;
        logic                    valid;
        logic                    done;
    } result_t;

endpackage

`default_nettype wire

### rtl/stl_fifo.sv
// ----------------------------------------------------------------------------
// stl_fifo
// Register queue with two write slots and one read port per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4    // power of two, at least 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en0,
    input  wire logic [WIDTH-1:0] wr_data0,
    input  wire logic             wr_en1,     // only together with wr_en0
    input  wire logic [WIDTH-1:0] wr_data1,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty,
    output logic                  full,
    output logic                  room2
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic             rd_fire;

    assign empty        = (count_reg == '0);
    assign full         = (count_reg == CNT_W'(DEPTH));
    assign room2        = (count_reg <= CNT_W'(DEPTH - 2));
    assign rd_data      = mem_reg[rd_ptr_reg];
    assign rd_fire      = rd_en && !empty;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(wr_en0) + PTR_W'(wr_en1);
        rd_ptr_next = rd_ptr_reg + PTR_W'(rd_fire);
        count_next  = count_reg + CNT_W'(wr_en0) + CNT_W'(wr_en1) - CNT_W'(rd_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en0)
        begin
            mem_reg[wr_ptr_reg] <= wr_data0;
        end
        if (wr_en1)
        begin
            mem_reg[wr_ptr_plus1] <= wr_data1;
        end
    end

endmodule

`default_nettype wire

### rtl/stl_front.sv
// ----------------------------------------------------------------------------
// stl_front
// Accepts source bytes, classifies them and queues them for the lexer core.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_front #(
    parameter int DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire logic [7:0]     byte_in,
    input  wire logic           end_of_input,
    output logic                full,
    input  wire logic           item_pop,
    output logic                item_valid,
    output stl_pkg::item_t      item
);

    localparam int ITEM_W = $bits(stl_pkg::item_t);

    stl_pkg::item_t   in_item;
    logic [ITEM_W-1:0] head_data;
    logic              queue_empty;
    logic              accept;

    function automatic stl_pkg::char_class_t classify(input logic [7:0] ch);
        stl_pkg::char_class_t cls;
        case (ch) inside
            8'h20, 8'h09, 8'h0D, 8'h0A: cls = stl_pkg::CLS_SPACE;
            8'h22:                      cls = stl_pkg::CLS_QUOTE;
            8'h28:                      cls = stl_pkg::CLS_LPAREN;
            8'h29:                      cls = stl_pkg::CLS_RPAREN;
            8'h7B:                      cls = stl_pkg::CLS_LBRACE;
            8'h7D:                      cls = stl_pkg::CLS_RBRACE;
            8'h5B:                      cls = stl_pkg::CLS_LBRACK;
            8'h5D:                      cls = stl_pkg::CLS_RBRACK;
            8'h30:                      cls = stl_pkg::CLS_ZERO;
            [8'h31:8'h39]:              cls = stl_pkg::CLS_DIGIT;
            // letters and _-+*/%&|!^~?:'><=
            [8'h41:8'h5A], [8'h61:8'h7A],
            8'h5F, 8'h2D, 8'h2B, 8'h2A, 8'h2F, 8'h25, 8'h26, 8'h7C,
            8'h21, 8'h5E, 8'h7E, 8'h3F, 8'h3A, 8'h27, 8'h3E, 8'h3C,
            8'h3D:                      cls = stl_pkg::CLS_IDENT;
            default:                    cls = stl_pkg::CLS_OTHER;
        endcase
        return cls;
    endfunction

    assign accept = push && !full;

    always_comb
    begin
        in_item.ch      = byte_in;
        in_item.eoi     = end_of_input;
        in_item.newline = (byte_in == 8'h0A);
        in_item.cls     = classify(byte_in);
    end

    stl_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en0   (accept),
        .wr_data0 (in_item),
        .wr_en1   (1'b0),
        .wr_data1 ('0),
        .rd_en    (item_pop),
        .rd_data  (head_data),
        .empty    (queue_empty),
        .full     (full),
        .room2    ()
    );

    assign item_valid = !queue_empty;
    assign item       = stl_pkg::item_t'(head_data);

endmodule

`default_nettype wire

### rtl/stl_back.sv
// ----------------------------------------------------------------------------
// stl_back
// Lexer core: token state, position counters and integer accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_back #(
    parameter int LINE_BITS   = 24,
    parameter int COLUMN_BITS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire stl_pkg::item_t  item,
    input  wire logic            out_room,
    output logic                 item_pop,
    output logic                 res0_valid,
    output stl_pkg::result_t     res0,
    output logic                 res1_valid,
    output stl_pkg::result_t     res1
);

    localparam int LF     = stl_pkg::LINE_FIELD_W;
    localparam int CF     = stl_pkg::COL_FIELD_W;
    localparam int VW     = stl_pkg::VALUE_W;
    localparam int LINE_W = (LINE_BITS < LF) ? LINE_BITS : LF;
    localparam int COL_W  = (COLUMN_BITS < CF) ? COLUMN_BITS : CF;

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_NUMBER = 5'b00010,
        MODE_IDENT  = 5'b00100,
        MODE_STRING = 5'b01000,
        MODE_DROP   = 5'b10000
    } lex_mode_t;

    lex_mode_t         mode_reg, mode_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] start_line_reg, start_line_next;
    logic [COL_W-1:0]  start_col_reg, start_col_next;
    logic [VW-1:0]     acc_reg, acc_next;

    logic [VW+3:0]     acc_sum;
    logic [VW-1:0]     acc_sat;
    logic [LF-1:0]     cur_line, st_line;
    logic [CF-1:0]     cur_col, st_col;
    logic              step;
    logic              open_lex;
    logic              a_valid, b_valid;
    stl_pkg::result_t  res_a, res_b;

    function automatic stl_pkg::result_t make_res(
        input logic [3:0]    kind,
        input logic [LF-1:0] line,
        input logic [CF-1:0] column,
        input logic [VW-1:0] value,
        input logic [7:0]    text,
        input logic          valid,
        input logic          done
    );
        stl_pkg::result_t r;
        r.kind   = kind;
        r.line   = line;
        r.column = column;
        r.value  = value;
        r.text   = valid ? text : 8'h00;
        r.valid  = valid;
        r.done   = done;
        return r;
    endfunction

    assign step     = item_valid && out_room;
    assign item_pop = step;
    assign cur_line = LF'(line_reg);
    assign cur_col  = CF'(col_reg);
    assign st_line  = LF'(start_line_reg);
    assign st_col   = CF'(start_col_reg);

    // acc * 10 + digit, saturating at the largest signed 64-bit value
    assign acc_sum = (VW+4)'({acc_reg, 3'b000}) + (VW+4)'({acc_reg, 1'b0})
                   + (VW+4)'(item.ch[3:0]);
    assign acc_sat = (|acc_sum[VW+3:VW]) ? {VW{1'b1}} : acc_sum[VW-1:0];

    always_comb
    begin
        mode_next       = mode_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        start_line_next = start_line_reg;
        start_col_next  = start_col_reg;
        acc_next        = acc_reg;
        open_lex        = 1'b0;
        a_valid         = 1'b0;
        b_valid         = 1'b0;
        res_a = make_res(stl_pkg::KIND_END, st_line, st_col, '0, 8'h00, 1'b0, 1'b1);
        res_b = make_res(stl_pkg::KIND_END, cur_line, cur_col, '0, 8'h00, 1'b0, 1'b1);

        if (step && item.eoi)
        begin
            // close any open token, then report end at the current position
            case (mode_reg)
                MODE_NUMBER:
                begin
                    a_valid = 1'b1;
                    res_a   = make_res(stl_pkg::KIND_INT, st_line, st_col, acc_reg,
                                       8'h00, 1'b0, 1'b1);
                end
                MODE_IDENT:
                begin
                    a_valid = 1'b1;
                    res_a   = make_res(stl_pkg::KIND_IDENT, st_line, st_col, '0,
                                       8'h00, 1'b0, 1'b1);
                end
                MODE_STRING:
                begin
                    a_valid = 1'b1;
                    res_a   = make_res(stl_pkg::KIND_UNTERM, st_line, st_col, '0,
                                       8'h00, 1'b0, 1'b1);
                end
                default:
                begin
                end
            endcase
            b_valid         = 1'b1;
            mode_next       = MODE_IDLE;
            line_next       = LINE_W'(1);
            col_next        = COL_W'(1);
            start_line_next = LINE_W'(1);
            start_col_next  = COL_W'(1);
            acc_next        = '0;
        end
        else if (step)
        begin
            // advance the position past this byte
            if (item.newline)
            begin
                if (line_reg != {LINE_W{1'b1}})
                begin
                    line_next = line_reg + 1'b1;
                end
                col_next = COL_W'(1);
            end
            else if (col_reg != {COL_W{1'b1}})
            begin
                col_next = col_reg + 1'b1;
            end

            case (mode_reg)
                MODE_NUMBER:
                begin
                    if (item.cls == stl_pkg::CLS_DIGIT || item.cls == stl_pkg::CLS_ZERO)
                    begin
                        acc_next = acc_sat;
                    end
                    else
                    begin
                        a_valid  = 1'b1;
                        res_a    = make_res(stl_pkg::KIND_INT, st_line, st_col, acc_reg,
                                            8'h00, 1'b0, 1'b1);
                        open_lex = 1'b1;
                    end
                end
                MODE_IDENT:
                begin
                    a_valid = 1'b1;
                    if (item.cls == stl_pkg::CLS_IDENT || item.cls == stl_pkg::CLS_DIGIT
                        || item.cls == stl_pkg::CLS_ZERO)
                    begin
                        res_a = make_res(stl_pkg::KIND_IDENT, st_line, st_col, '0,
                                         item.ch, 1'b1, 1'b0);
                    end
                    else
                    begin
                        res_a    = make_res(stl_pkg::KIND_IDENT, st_line, st_col, '0,
                                            8'h00, 1'b0, 1'b1);
                        open_lex = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    a_valid = 1'b1;
                    if (item.cls == stl_pkg::CLS_QUOTE)
                    begin
                        res_a     = make_res(stl_pkg::KIND_STRING, st_line, st_col, '0,
                                             8'h00, 1'b0, 1'b1);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        res_a = make_res(stl_pkg::KIND_STRING, st_line, st_col, '0,
                                         item.ch, 1'b1, 1'b0);
                    end
                end
                MODE_DROP:
                begin
                end
                default:
                begin
                    open_lex = 1'b1;
                end
            endcase

            // lex the byte afresh as the start of a new token
            if (open_lex)
            begin
                start_line_next = line_reg;
                start_col_next  = col_reg;
                acc_next        = '0;
                mode_next       = MODE_IDLE;
                case (item.cls)
                    stl_pkg::CLS_SPACE:
                    begin
                    end
                    stl_pkg::CLS_QUOTE:
                    begin
                        mode_next = MODE_STRING;
                    end
                    stl_pkg::CLS_LPAREN:
                    begin
                        b_valid    = 1'b1;
                        res_b.kind = stl_pkg::KIND_LPAREN;
                    end
                    stl_pkg::CLS_RPAREN:
                    begin
                        b_valid    = 1'b1;
                        res_b.kind = stl_pkg::KIND_RPAREN;
                    end
                    stl_pkg::CLS_LBRACE:
                    begin
                        b_valid    = 1'b1;
                        res_b.kind = stl_pkg::KIND_LBRACE;
                    end
                    stl_pkg::CLS_RBRACE:
                    begin
                        b_valid    = 1'b1;
                        res_b.kind = stl_pkg::KIND_RBRACE;
                    end
                    stl_pkg::CLS_LBRACK:
                    begin
                        b_valid    = 1'b1;
                        res_b.kind = stl_pkg::KIND_LBRACK;
                    end
                    stl_pkg::CLS_RBRACK:
                    begin
                        b_valid    = 1'b1;
                        res_b.kind = stl_pkg::KIND_RBRACK;
                    end
                    stl_pkg::CLS_DIGIT:
                    begin
                        acc_next  = VW'(item.ch[3:0]);
                        mode_next = MODE_NUMBER;
                    end
                    stl_pkg::CLS_IDENT:
                    begin
                        b_valid   = 1'b1;
                        res_b     = make_res(stl_pkg::KIND_IDENT, cur_line, cur_col, '0,
                                             item.ch, 1'b1, 1'b0);
                        mode_next = MODE_IDENT;
                    end
                    default:
                    begin
                        // leading zero or stray byte: report it and drop the rest
                        b_valid   = 1'b1;
                        res_b     = make_res(stl_pkg::KIND_BADCHAR, cur_line, cur_col, '0,
                                             item.ch, 1'b1, 1'b1);
                        mode_next = MODE_DROP;
                    end
                endcase
            end
        end
    end

    // pack the results so the first one always sits in slot 0
    always_comb
    begin
        res0_valid = a_valid || b_valid;
        res0       = a_valid ? res_a : res_b;
        res1_valid = a_valid && b_valid;
        res1       = res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            line_reg       <= LINE_W'(1);
            col_reg        <= COL_W'(1);
            start_line_reg <= LINE_W'(1);
            start_col_reg  <= COL_W'(1);
            acc_reg        <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            start_line_reg <= start_line_next;
            start_col_reg  <= start_col_next;
            acc_reg        <= acc_next;
        end
    end

endmodule

`default_nettype wire

### rtl/sexpr_token_lexer.sv
// ----------------------------------------------------------------------------
// sexpr_token_lexer
// Streaming lexer for s-expression source text, one byte per request.
// ----------------------------------------------------------------------------
// Push one source byte per clock (or an end-of-input mark); the block keeps
// up at one byte per clock while the result queue has room for two results.
// Bytes and results pass through registered queues. Most bytes give zero
// or one result; a byte that ends an integer or identifier and also begins a
// new token gives two, as does an end-of-input mark that closes an open
// token, and the result queue drains at one result per pop, so the result
// side sets the pace during long runs of such requests. The input queue
// holds FRONT_DEPTH bytes and the result queue OUT_DEPTH results; the lexer
// core takes a byte from the input queue whenever the result queue has room
// for two results. LINE_BITS and COLUMN_BITS set the saturation points of
// the position counters (never beyond the 24-bit and 16-bit ports).
`default_nettype none

module sexpr_token_lexer #(
    parameter int LINE_BITS   = 24,
    parameter int COLUMN_BITS = 16,
    parameter int FRONT_DEPTH = 2,   // power of two
    parameter int OUT_DEPTH   = 4    // power of two, at least 4 for full rate
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  byte_in,
    input  wire logic        end_of_input,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       token_kind,
    output logic [23:0]      token_line,
    output logic [15:0]      token_column,
    output logic [62:0]      int_value,
    output logic [7:0]       text_byte,
    output logic             byte_valid,
    output logic             token_done
);

    localparam int RES_W = $bits(stl_pkg::result_t);

    stl_pkg::item_t    item;
    logic              item_valid;
    logic              item_pop;
    logic              out_room;
    logic              res0_valid, res1_valid;
    stl_pkg::result_t  res0, res1;
    logic [RES_W-1:0]  head_data;
    stl_pkg::result_t  head;

    stl_front #(
        .DEPTH (FRONT_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .byte_in      (byte_in),
        .end_of_input (end_of_input),
        .full         (full),
        .item_pop     (item_pop),
        .item_valid   (item_valid),
        .item         (item)
    );

    stl_back #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_room   (out_room),
        .item_pop   (item_pop),
        .res0_valid (res0_valid),
        .res0       (res0),
        .res1_valid (res1_valid),
        .res1       (res1)
    );

    stl_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en0   (res0_valid),
        .wr_data0 (res0),
        .wr_en1   (res1_valid),
        .wr_data1 (res1),
        .rd_en    (pop),
        .rd_data  (head_data),
        .empty    (empty),
        .full     (),
        .room2    (out_room)
    );

    assign head = stl_pkg::result_t'(head_data);

    always_comb
    begin
        token_kind   = head.kind;
        token_line   = head.line;
        token_column = head.column;
        int_value    = head.value;
        text_byte    = head.text;
        byte_valid   = head.valid;
        token_done   = head.done;
    end

endmodule

`default_nettype wire

### rtl/stl_checker.sv
// ----------------------------------------------------------------------------
// stl_checker
// Port-level checks on the result side of the lexer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sexpr_token_lexer_macros.svh"

module stl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [3:0]  token_kind,
    input wire logic [23:0] token_line,
    input wire logic [15:0] token_column,
    input wire logic [62:0] int_value,
    input wire logic [7:0]  text_byte,
    input wire logic        byte_valid,
    input wire logic        token_done
);

    // kind code stays within the defined token kinds
    `STL_ASSERT_NOW(a_kind_range, clk, rst_n, !empty, token_kind <= stl_pkg::KIND_UNTERM)

    // positions count from one
    `STL_ASSERT_NOW(a_pos_nonzero, clk, rst_n, !empty, token_line != 24'd0 && token_column != 16'd0)

    // only integer tokens carry a value
    `STL_ASSERT_NOW(a_value_int_only, clk, rst_n, !empty && token_kind != stl_pkg::KIND_INT,
                    int_value == 63'd0)

    // a result without a character has a zero byte and closes its token
    `STL_ASSERT_NOW(a_empty_byte, clk, rst_n, !empty && !byte_valid,
                    text_byte == 8'd0 && token_done)

    // a waiting result holds until taken
    `STL_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop,
                     !empty && $stable(token_kind) && $stable(token_line) && $stable(text_byte))

endmodule

bind sexpr_token_lexer stl_checker u_stl_checker (.*);

`default_nettype wire
